@@ src/hrhp_pkg.sv @@
// Package for the HTTP response head parser: event codes, result records and
// the per-byte result bundle passed from the front end to the back end.
// No dependencies.
`default_nettype none
package hrhp_pkg;

	localparam int OFF_W  = 17;
	localparam int CODE_W = 10;
	localparam int MAX_RES = 3;
	localparam logic [OFF_W-1:0] OFF_MAX = '1;

	typedef enum logic [2:0] {
		EV_LINE       = 3'd0,
		EV_FOLD       = 3'd1,
		EV_STATUS     = 3'd2,
		EV_END        = 3'd3,
		EV_HEADERLESS = 3'd4,
		EV_BIG        = 3'd5
	} ev_t;

	typedef struct packed {
		ev_t               ev;
		logic [OFF_W-1:0]  pos;
		logic [OFF_W-1:0]  pend;
		logic              crf;
		logic [CODE_W-1:0] code;
		logic              ok;
		logic              inc;
	} rec_t;

	typedef struct packed {
		logic [1:0]             cnt;
		rec_t [MAX_RES-1:0]     rec;
	} bundle_t;

	function automatic rec_t mk_rec(ev_t ev, logic [OFF_W-1:0] pos, logic [OFF_W-1:0] pend,
		logic crf, logic [CODE_W-1:0] code, logic ok, logic inc);
		rec_t r;
		r.ev   = ev;
		r.pos  = pos;
		r.pend = pend;
		r.crf  = crf;
		r.code = code;
		r.ok   = ok;
		r.inc  = inc;
		return r;
	endfunction

	function automatic logic [OFF_W-1:0] sat_inc(logic [OFF_W-1:0] v);
		return (v == OFF_MAX) ? OFF_MAX : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

@@ src/hrhp_front.sv @@
// Front end: accepts response bytes, runs the parse state and packs the
// results of each byte into one bundle. Depends on hrhp_pkg.
`default_nettype none
module hrhp_front import hrhp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_fire,
	input  wire logic             kind,
	input  wire logic [7:0]       data_byte,
	input  wire logic             cfg_fire,
	input  wire logic [OFF_W-1:0] cfg_data,
	output bundle_t               bundle,
	output logic                  push
);

	typedef enum logic [2:0] {
		PH_PREFIX = 3'b001,
		PH_HEAD   = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		NL_NONE = 3'b001,
		NL_LF   = 3'b010,
		NL_LFCR = 3'b100
	} nl_t;

	typedef enum logic [9:0] {
		SP_VER0     = 10'b00_0000_0001,
		SP_VMAJ     = 10'b00_0000_0010,
		SP_VMIN     = 10'b00_0000_0100,
		SP_WS1      = 10'b00_0000_1000,
		SP_D1       = 10'b00_0001_0000,
		SP_D2       = 10'b00_0010_0000,
		SP_WS2      = 10'b00_0100_0000,
		SP_REASON   = 10'b00_1000_0000,
		SP_BAD      = 10'b01_0000_0000,
		SP_REPORTED = 10'b10_0000_0000
	} sp_t;

	phase_t            phase_q, phase_n;
	nl_t               nl_q, nl_n;
	sp_t               sp_q, sp_n;
	logic [2:0]        pidx_q, pidx_n;
	logic [OFF_W-1:0]  off_q, off_n;
	logic [OFF_W-1:0]  nl_off_q, nl_off_n;
	logic [CODE_W-1:0] val_q, val_n;
	logic [OFF_W-1:0]  rb_q, rb_n;
	logic [OFF_W-1:0]  rl_q, rl_n;
	logic              last_cr_q, last_cr_n;
	logic              lf_cr_q, lf_cr_n;
	logic [OFF_W-1:0]  limit_q;

	logic              st_emit;
	rec_t              st_rec;
	logic [7:0]        magic;
	logic [3:0]        dig;

	function automatic logic is_ws(logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b || b == 8'h0c ||
			b == 8'h0d;
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	always_comb begin
		unique case (pidx_q[1:0])
			2'd0: magic = 8'h48;
			2'd1: magic = 8'h54;
			2'd2: magic = 8'h54;
			default: magic = 8'h50;
		endcase
	end

	assign dig = 4'(data_byte - 8'h30);

	// Status report as it would be given at the current offset.
	always_comb begin
		st_emit = (sp_q != SP_REPORTED);
		if (sp_q == SP_WS2)
			st_rec = mk_rec(EV_STATUS, off_q, off_q, 1'b0, val_q, 1'b1, 1'b0);
		else if (sp_q == SP_REASON)
			st_rec = mk_rec(EV_STATUS, rb_q, sat_inc(rl_q), 1'b0, val_q, 1'b1, 1'b0);
		else
			st_rec = mk_rec(EV_STATUS, '0, '0, 1'b0, '0, 1'b0, 1'b0);
	end

	always_comb begin
		logic [1:0] n;
		sp_t        eff;
		logic       stop;
		logic       term;
		n         = 2'd0;
		eff       = sp_q;
		stop      = 1'b0;
		term      = 1'b0;
		bundle    = '0;
		phase_n   = phase_q;
		nl_n      = nl_q;
		sp_n      = sp_q;
		pidx_n    = pidx_q;
		off_n     = off_q;
		nl_off_n  = nl_off_q;
		val_n     = val_q;
		rb_n      = rb_q;
		rl_n      = rl_q;
		last_cr_n = last_cr_q;
		lf_cr_n   = lf_cr_q;
		if (in_fire && phase_q != PH_DONE) begin
			if (kind) begin
				if (phase_q == PH_PREFIX && pidx_q == 3'd0) begin
					bundle.rec[n] = mk_rec(EV_HEADERLESS, '0, '0, 1'b0, 10'd200, 1'b1, 1'b0);
					n = n + 2'd1;
				end else begin
					bundle.rec[n] = mk_rec(EV_LINE, off_q, '0, 1'b0, '0, 1'b0, 1'b0);
					n = n + 2'd1;
					if (st_emit) begin
						bundle.rec[n] = st_rec;
						n = n + 2'd1;
					end
					sp_n = SP_REPORTED;
					bundle.rec[n] = mk_rec(EV_END, off_q, '0, 1'b0, '0, 1'b0, 1'b1);
					n = n + 2'd1;
				end
				phase_n = PH_DONE;
			end else if (phase_q == PH_PREFIX && data_byte != magic) begin
				bundle.rec[n] = mk_rec(EV_HEADERLESS, '0, '0, 1'b0, 10'd200, 1'b1, 1'b0);
				n = n + 2'd1;
				phase_n = PH_DONE;
			end else if (limit_q != '0 && off_q >= limit_q) begin
				bundle.rec[n] = mk_rec(EV_BIG, off_q, '0, 1'b0, '0, 1'b0, 1'b0);
				n = n + 2'd1;
				phase_n = PH_DONE;
			end else begin
				if (phase_q == PH_PREFIX) begin
					if (pidx_q == 3'd0) begin
						bundle.rec[n] = mk_rec(EV_LINE, '0, '0, 1'b0, '0, 1'b0, 1'b0);
						n = n + 2'd1;
					end
					pidx_n = pidx_q + 3'd1;
					if (pidx_q == 3'd3)
						phase_n = PH_HEAD;
				end else begin
					// A pending LF either folds or closes the line.
					if (nl_q == NL_LF) begin
						if (data_byte == 8'h20 || data_byte == 8'h09) begin
							bundle.rec[n] = mk_rec(EV_FOLD, nl_off_q,
								lf_cr_q ? nl_off_q - 1'b1 : '0, lf_cr_q, '0, 1'b0, 1'b0);
							n = n + 2'd1;
						end else begin
							bundle.rec[n] = mk_rec(EV_LINE, off_q, '0, 1'b0, '0, 1'b0, 1'b0);
							n = n + 2'd1;
							if (st_emit) begin
								bundle.rec[n] = st_rec;
								n = n + 2'd1;
							end
							eff = SP_REPORTED;
						end
					end
					// Status line scan; version states fall through to WS1.
					unique case (eff)
						SP_VER0: begin
							if (data_byte == 8'h2f) begin
								sp_n = SP_VMAJ;
								stop = 1'b1;
							end else eff = SP_WS1;
						end
						SP_VMAJ: begin
							if (is_digit(data_byte)) stop = 1'b1;
							else if (data_byte == 8'h2e) begin
								sp_n = SP_VMIN;
								stop = 1'b1;
							end else eff = SP_WS1;
						end
						SP_VMIN: begin
							if (is_digit(data_byte)) stop = 1'b1;
							else eff = SP_WS1;
						end
						default: ;
					endcase
					if (!stop) begin
						sp_n = eff;
						unique case (eff)
							SP_WS1: begin
								if (!is_ws(data_byte)) begin
									if (is_digit(data_byte)) begin
										val_n = {6'd0, dig} * 10'd100;
										sp_n  = SP_D1;
									end else sp_n = SP_BAD;
								end
							end
							SP_D1: begin
								if (is_digit(data_byte)) begin
									val_n = val_q + {6'd0, dig} * 10'd10;
									sp_n  = SP_D2;
								end else sp_n = SP_BAD;
							end
							SP_D2: begin
								if (is_digit(data_byte)) begin
									val_n = val_q + {6'd0, dig};
									sp_n  = SP_WS2;
								end else sp_n = SP_BAD;
							end
							SP_WS2: begin
								if (!is_ws(data_byte)) begin
									rb_n = off_q;
									rl_n = off_q;
									sp_n = SP_REASON;
								end
							end
							SP_REASON: begin
								if (!is_ws(data_byte)) rl_n = off_q;
							end
							default: ;
						endcase
					end
					term = (data_byte == 8'h0a) && (nl_q != NL_NONE);
					if (data_byte == 8'h0a) begin
						nl_n     = NL_LF;
						nl_off_n = off_q;
						lf_cr_n  = last_cr_q;
					end else if (data_byte == 8'h0d && nl_q == NL_LF) begin
						nl_n = NL_LFCR;
					end else begin
						nl_n = NL_NONE;
					end
					last_cr_n = (data_byte == 8'h0d);
					if (term) begin
						bundle.rec[n] = mk_rec(EV_END, sat_inc(off_q), '0, 1'b0, '0, 1'b0, 1'b0);
						n = n + 2'd1;
						phase_n = PH_DONE;
					end
				end
				off_n = sat_inc(off_q);
			end
		end
		bundle.cnt = n;
		push = (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PREFIX;
			nl_q      <= NL_NONE;
			sp_q      <= SP_VER0;
			pidx_q    <= '0;
			off_q     <= '0;
			nl_off_q  <= '0;
			val_q     <= '0;
			rb_q      <= '0;
			rl_q      <= '0;
			last_cr_q <= 1'b0;
			lf_cr_q   <= 1'b0;
			limit_q   <= OFF_W'(65536);
		end else begin
			phase_q   <= phase_n;
			nl_q      <= nl_n;
			sp_q      <= sp_n;
			pidx_q    <= pidx_n;
			off_q     <= off_n;
			nl_off_q  <= nl_off_n;
			val_q     <= val_n;
			rb_q      <= rb_n;
			rl_q      <= rl_n;
			last_cr_q <= last_cr_n;
			lf_cr_q   <= lf_cr_n;
			if (cfg_fire) limit_q <= cfg_data;
		end
	end

endmodule
`default_nettype wire

@@ src/hrhp_queue.sv @@
// Short bundle queue between the parse front end and the result back end.
// Depends on hrhp_pkg.
`default_nettype none
module hrhp_queue import hrhp_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire bundle_t wr_data,
	input  wire logic    pop,
	output bundle_t      rd_data,
	output logic         full,
	output logic         not_empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [CW-1:0]   cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule
`default_nettype wire

@@ src/hrhp_back.sv @@
// Back end: unpacks each bundle into single result requests and tags the
// last one of each byte. Depends on hrhp_pkg.
`default_nettype none
module hrhp_back import hrhp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire bundle_t q_data,
	input  wire logic    q_valid,
	output logic         q_pop,
	output logic         out_valid,
	input  wire logic    out_ready,
	output rec_t         rec,
	output logic         last
);

	bundle_t    cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       take;

	assign out_valid = busy_q;
	assign rec       = cur_q.rec[idx_q];
	assign last      = (idx_q == cur_q.cnt - 2'd1);
	assign take      = busy_q && out_ready;
	assign q_pop     = q_valid && (!busy_q || (take && last));

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (last) busy_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

@@ src/http_response_head_parser.sv @@
// HTTP response head parser, top level. Depends on hrhp_pkg, hrhp_front,
// hrhp_queue and hrhp_back.
// Throughput: one byte per cycle while the result side keeps up; a byte that
// yields more than one result (up to 3) holds the result port until all are taken.
// Path: the first result of a byte is written into the queue at the edge that
// accepts its request, then loaded into the back end's register and offered.
// Reset: arst_n clears all parse state and queues at once; the size limit
// returns to 65536. No clearing pass.
`default_nettype none
module http_response_head_parser import hrhp_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              kind,
	input  wire logic [7:0]        data_byte,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [OFF_W-1:0]  cfg_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             event_res,
	output logic [OFF_W-1:0]       position,
	output logic [OFF_W-1:0]       position_end,
	output logic                   cr_folded,
	output logic [CODE_W-1:0]      status_code,
	output logic                   status_ok,
	output logic                   incomplete,
	output logic                   last_of_run
);

	bundle_t f_bundle, q_bundle;
	logic    f_push, q_full, q_nonempty, q_pop;
	rec_t    b_rec;

	// Take a byte whenever the queue has a free slot, even while results wait.
	assign in_ready  = !q_full;
	assign cfg_ready = 1'b1;

	hrhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_valid && in_ready),
		.kind      (kind),
		.data_byte (data_byte),
		.cfg_fire  (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.bundle    (f_bundle),
		.push      (f_push)
	);

	// Bytes without results are dropped before the queue.
	hrhp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.wr_data   (f_bundle),
		.pop       (q_pop),
		.rd_data   (q_bundle),
		.full      (q_full),
		.not_empty (q_nonempty)
	);

	hrhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_bundle),
		.q_valid   (q_nonempty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rec       (b_rec),
		.last      (last_of_run)
	);

	assign event_res    = b_rec.ev;
	assign position     = b_rec.pos;
	assign position_end = b_rec.pend;
	assign cr_folded    = b_rec.crf;
	assign status_code  = b_rec.code;
	assign status_ok    = b_rec.ok;
	assign incomplete   = b_rec.inc;

	// Terminal events always close their run.
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_END || event_res == EV_HEADERLESS ||
		event_res == EV_BIG) |-> last_of_run)
		else $error("terminal event not last of run");

	// Nothing follows a delivered terminal event.
	a_term_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (event_res == EV_END || event_res == EV_HEADERLESS ||
		event_res == EV_BIG) |=> !out_valid)
		else $error("result after terminal event");

	// Headerless reports status 200 as well formed.
	a_headerless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_HEADERLESS |-> status_code == 10'd200 && status_ok)
		else $error("bad headerless fields");

endmodule
`default_nettype wire
